FILE: rtl/core/room_light_effect_engine_core_defines.svh
// Assertion helpers used by the engine core.
`ifndef ROOM_LIGHT_EFFECT_ENGINE_CORE_DEFINES_SVH
`define ROOM_LIGHT_EFFECT_ENGINE_CORE_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define RLEE_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define RLEE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rlee_pkg.sv
package rlee_pkg;

   localparam int ROOM_COUNT   = 4;
   localparam int ROOM_W       = $clog2(ROOM_COUNT);
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);

   localparam logic [14:0] BRIGHT_MAX   = 15'd25600;
   localparam logic [15:0] HUE_FULL     = 16'd23040;
   localparam logic [11:0] SECTOR       = 12'd3840;
   localparam logic [14:0] BRIGHT_RESET = 15'd15360;
   localparam logic [14:0] HUE_RESET    = 15'd13440;
   localparam logic [15:0] SPEED_RESET  = 16'd256;

   localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
   localparam logic [23:0] ROOM_PHASE_STEP = 24'd1602106;
   localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;

   // 65535*b*w / (25600*19200) = ((65535*b*(w/4)) >> 16) / 1875
   localparam logic [31:0] RECIP_1875   = 32'd146601551;
   localparam int          RECIP_SHIFT  = 38;
   localparam logic [12:0] W_MAX        = 13'd4800;
   localparam logic [12:0] W_MIN        = 13'd960;

   typedef enum logic [1:0] {
      OP_SET_ROOM   = 2'd0,
      OP_SET_EFFECT = 2'd1,
      OP_TICK       = 2'd2,
      OP_READ_COLOR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EFF_NONE  = 2'd0,
      EFF_PULSE = 2'd1,
      EFF_WAVE  = 2'd2,
      EFF_OFF   = 2'd3
   } effect_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  room;
      logic        light_on;
      logic [14:0] level;
      logic [15:0] hue_in;
      logic [1:0]  effect_kind;
      logic [15:0] rate;
      logic [15:0] depth;
      logic [31:0] time_now;
   } req_item_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rsp_item_type;

   function automatic logic signed [15:0] sine_sample(int unsigned k);
      logic [31:0]        p;
      logic [1:0]         quad;
      logic [63:0]        r;
      logic [63:0]        a;
      logic [63:0]        a2;
      logic [63:0]        term;
      logic [63:0]        v;
      longint             sum;
      logic signed [15:0] mag;
      p    = 32'(k) << (32 - SINE_BITS);
      quad = p[31:30];
      r    = {34'd0, p[29:0]};
      if (quad[0]) begin
         r = 64'h4000_0000 - r;
      end
      a    = (r * PI_HALF_Q30) >> 30;
      a2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      term = ((term * a2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * a2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * a2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * a2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * a2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      mag = v[15:0];
      return quad[1] ? -mag : mag;
   endfunction

endpackage

FILE: rtl/core/rlee_mul.sv
module rlee_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;
endmodule

FILE: rtl/core/rlee_sine_rom.sv
module rlee_sine_rom (
   input  logic                            clock,
   input  logic [rlee_pkg::SINE_BITS-1:0]  addr,
   output logic signed [15:0]              data
);
   import rlee_pkg::*;

   logic signed [15:0] sine_rom [SINE_ENTRIES];
   logic signed [15:0] data_ff;

   initial begin
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         sine_rom[k] = sine_sample(k);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= sine_rom[addr];
   end

   assign data = data_ff;
endmodule

FILE: rtl/core/room_light_effect_engine_core.sv
// Room light effect engine.
// Input channel: present an item on req_item and raise start; it is taken at
// the rising edge where start is high and busy is low.
// set_room and set_effect complete at that edge and keep busy low.
// A tick walks all rooms on one shared 32x32 multiplier and the sine ROM:
// a room without an effect only passes the scan state; a pulse or wave room
// goes through scan, mul_hi, mul_lo, phase, amp and apply.
// read_color runs the multiplier twice per color channel: a setup state, then
// rd_mul, rd_recip and rd_done for each channel before the result strobe.
// The result is valid on rsp_item in the one cycle rsp_valid is high;
// the receiver cannot stall and must take it then. Only read_color answers.
// Reset (synchronous, active high) returns every room to on, 60 percent,
// 210 degrees, no effect, 1 Hz, zero amount, and leaves the block idle.
`include "room_light_effect_engine_core_defines.svh"

module room_light_effect_engine_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rlee_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output rlee_pkg::rsp_item_type rsp_item
);
   import rlee_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_PHASE,
      ST_AMP,
      ST_APPLY,
      ST_RD_SETUP,
      ST_RD_MUL,
      ST_RD_RECIP,
      ST_RD_DONE
   } state_type;

   localparam logic [ROOM_W-1:0] ROOM_LAST = ROOM_W'(ROOM_COUNT - 1);

   state_type          state_ff, state_in;
   logic [ROOM_W-1:0]  room_ff, room_in;
   logic [1:0]         chan_ff, chan_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic [31:0]        time_ff, time_in;
   logic [23:0]        prod_ff, prod_in;
   logic [31:0]        hi_ff, hi_in;
   logic               s_neg_ff, s_neg_in;
   logic [14:0]        b_ff, b_in;
   logic [12:0]        w_ff [3];
   logic [12:0]        w_in [3];

   logic               on_ff     [ROOM_COUNT];
   logic               on_in     [ROOM_COUNT];
   logic [14:0]        bright_ff [ROOM_COUNT];
   logic [14:0]        bright_in [ROOM_COUNT];
   logic [14:0]        hue_ff    [ROOM_COUNT];
   logic [14:0]        hue_in    [ROOM_COUNT];
   logic [1:0]         effect_ff [ROOM_COUNT];
   logic [1:0]         effect_in [ROOM_COUNT];
   logic [15:0]        speed_ff  [ROOM_COUNT];
   logic [15:0]        speed_in  [ROOM_COUNT];
   logic [15:0]        amount_ff [ROOM_COUNT];
   logic [15:0]        amount_in [ROOM_COUNT];

   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p;
   logic [SINE_BITS-1:0] rom_addr;
   logic signed [15:0]   rom_data;

   logic [ROOM_W-1:0]  wr_room;
   logic               wr_ok;
   logic [14:0]        level_clamped;
   logic [15:0]        hue_reduced;
   logic [1:0]         cur_eff;
   logic               cur_active;
   logic [56:0]        wave_sum;
   logic [23:0]        phase_raw;
   logic [27:0]        room_offset;
   logic [23:0]        phase;
   logic [15:0]        s_abs;
   logic [33:0]        m5;
   logic [34:0]        bd_sum;
   logic [34:0]        hd_sum;
   logic [14:0]        bd;
   logic [12:0]        hd;
   logic [15:0]        nb_up;
   logic [14:0]        nb;
   logic [15:0]        nh_up;
   logic [14:0]        nh;
   logic [14:0]        rd_hue;
   logic [2:0]         sec;
   logic [15:0]        sec_base;
   logic [11:0]        sec_f;
   logic [11:0]        sec_g;
   logic [12:0]        w_mid;
   logic [42:0]        y_full;

   rlee_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   rlee_sine_rom u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign wr_room = req_item.room[ROOM_W-1:0];
   assign wr_ok   = int'(req_item.room) < ROOM_COUNT;

   always_comb begin
      level_clamped = (req_item.level > BRIGHT_MAX) ? BRIGHT_MAX : req_item.level;
      if (req_item.hue_in >= 16'(2 * HUE_FULL)) begin
         hue_reduced = req_item.hue_in - 16'(2 * HUE_FULL);
      end else if (req_item.hue_in >= HUE_FULL) begin
         hue_reduced = req_item.hue_in - HUE_FULL;
      end else begin
         hue_reduced = req_item.hue_in;
      end
   end

   assign cur_eff    = effect_ff[room_ff];
   assign cur_active = (cur_eff == EFF_PULSE) || (cur_eff == EFF_WAVE);

   // phase of the current room in 1/2^24 turn
   assign wave_sum    = {1'b0, hi_ff, 24'd0} + {1'b0, mul_p[55:0]};
   assign phase_raw   = (cur_eff == EFF_WAVE) ? wave_sum[55:32] : prod_ff;
   assign room_offset = 28'(room_ff) * 28'(ROOM_PHASE_STEP);
   assign phase       = phase_raw + room_offset[23:0];
   assign rom_addr    = phase[23 -: SINE_BITS];
   assign s_abs       = rom_data[15] ? 16'(-rom_data) : 16'(rom_data);

   // sample times amount times 5120 or 1280, rounded on the magnitude
   always_comb begin
      m5     = {3'd0, mul_p[30:0]} + {1'b0, mul_p[30:0], 2'd0};
      bd_sum = {1'b0, m5} + 35'(1 << 19);
      hd_sum = {1'b0, m5} + 35'(1 << 21);
      bd     = bd_sum[34:20];
      hd     = hd_sum[34:22];
      nb_up  = {1'b0, bright_ff[room_ff]} + {1'b0, bd};
      if (s_neg_ff) begin
         nb = (bd > bright_ff[room_ff]) ? 15'd0 : bright_ff[room_ff] - bd;
      end else begin
         nb = (nb_up > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX : nb_up[14:0];
      end
      if (s_neg_ff) begin
         if ({2'd0, hd} > hue_ff[room_ff]) begin
            nh_up = {1'b0, hue_ff[room_ff]} + HUE_FULL - {3'd0, hd};
         end else begin
            nh_up = {1'b0, hue_ff[room_ff]} - {3'd0, hd};
         end
      end else begin
         nh_up = {1'b0, hue_ff[room_ff]} + {3'd0, hd};
         if (nh_up >= HUE_FULL) begin
            nh_up = nh_up - HUE_FULL;
         end
      end
      nh = nh_up[14:0];
   end

   // hue sector and channel weights (weights in quarter units)
   always_comb begin
      rd_hue = hue_ff[room_ff];
      if ({1'b0, rd_hue} >= 16'(5 * SECTOR)) begin
         sec = 3'd5;
      end else if ({1'b0, rd_hue} >= 16'(4 * SECTOR)) begin
         sec = 3'd4;
      end else if ({1'b0, rd_hue} >= 16'(3 * SECTOR)) begin
         sec = 3'd3;
      end else if ({1'b0, rd_hue} >= 16'(2 * SECTOR)) begin
         sec = 3'd2;
      end else if ({1'b0, rd_hue} >= 16'(SECTOR)) begin
         sec = 3'd1;
      end else begin
         sec = 3'd0;
      end
      sec_base = 16'(sec) * 16'(SECTOR);
      sec_f    = 12'({1'b0, rd_hue} - sec_base);
      sec_g    = sec[0] ? SECTOR - sec_f : sec_f;
      w_mid    = W_MIN + 13'(sec_g);
   end

   assign y_full = {mul_p[26:0], 16'd0} - {16'd0, mul_p[26:0]};

   always_comb begin
      state_in     = state_ff;
      room_in      = room_ff;
      chan_in      = chan_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      time_in      = time_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      s_neg_in     = s_neg_ff;
      b_in         = b_ff;
      w_in         = w_ff;
      on_in        = on_ff;
      bright_in    = bright_ff;
      hue_in       = hue_ff;
      effect_in    = effect_ff;
      speed_in     = speed_ff;
      amount_in    = amount_ff;
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op_type'(req_item.operation))
                  OP_SET_ROOM: begin
                     if (wr_ok) begin
                        on_in[wr_room]     = req_item.light_on;
                        bright_in[wr_room] = level_clamped;
                        hue_in[wr_room]    = hue_reduced[14:0];
                     end
                  end
                  OP_SET_EFFECT: begin
                     if (wr_ok) begin
                        effect_in[wr_room] = req_item.effect_kind;
                        speed_in[wr_room]  = req_item.rate;
                        amount_in[wr_room] = req_item.depth;
                     end
                  end
                  OP_TICK: begin
                     time_in  = req_item.time_now;
                     room_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     room_in  = wr_room;
                     state_in = ST_RD_SETUP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cur_active) begin
               mul_a    = time_ff;
               mul_b    = {16'd0, speed_ff[room_ff]};
               state_in = ST_MUL_HI;
            end else if (room_ff == ROOM_LAST) begin
               state_in = ST_IDLE;
            end else begin
               room_in = room_ff + 1'b1;
            end
         end
         ST_MUL_HI: begin
            prod_in  = mul_p[23:0];
            mul_a    = {8'd0, mul_p[47:24]};
            mul_b    = INV_TWO_PI_Q32;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            hi_in    = mul_p[31:0];
            mul_a    = {8'd0, prod_ff};
            mul_b    = INV_TWO_PI_Q32;
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            state_in = ST_AMP;
         end
         ST_AMP: begin
            s_neg_in = rom_data[15];
            mul_a    = {16'd0, s_abs};
            mul_b    = {16'd0, amount_ff[room_ff]};
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            bright_in[room_ff] = nb;
            if (cur_eff == EFF_WAVE) begin
               hue_in[room_ff] = nh;
            end
            if (room_ff == ROOM_LAST) begin
               state_in = ST_IDLE;
            end else begin
               room_in  = room_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_RD_SETUP: begin
            b_in    = on_ff[room_ff] ? bright_ff[room_ff] : 15'd0;
            chan_in = 2'd0;
            case (sec)
               3'd0: begin w_in[0] = W_MAX; w_in[1] = w_mid; w_in[2] = W_MIN; end
               3'd1: begin w_in[0] = w_mid; w_in[1] = W_MAX; w_in[2] = W_MIN; end
               3'd2: begin w_in[0] = W_MIN; w_in[1] = W_MAX; w_in[2] = w_mid; end
               3'd3: begin w_in[0] = W_MIN; w_in[1] = w_mid; w_in[2] = W_MAX; end
               3'd4: begin w_in[0] = w_mid; w_in[1] = W_MIN; w_in[2] = W_MAX; end
               default: begin w_in[0] = W_MAX; w_in[1] = W_MIN; w_in[2] = w_mid; end
            endcase
            state_in = ST_RD_MUL;
         end
         ST_RD_MUL: begin
            mul_a    = {17'd0, b_ff};
            mul_b    = {19'd0, w_ff[chan_ff]};
            state_in = ST_RD_RECIP;
         end
         ST_RD_RECIP: begin
            mul_a    = {5'd0, y_full[42:16]};
            mul_b    = RECIP_1875;
            state_in = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            case (chan_ff)
               2'd0:    rsp_in.red   = mul_p[RECIP_SHIFT +: 16];
               2'd1:    rsp_in.green = mul_p[RECIP_SHIFT +: 16];
               default: rsp_in.blue  = mul_p[RECIP_SHIFT +: 16];
            endcase
            if (chan_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_RD_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         room_ff      <= '0;
         chan_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ROOM_COUNT; i++) begin
            on_ff[i]     <= 1'b1;
            bright_ff[i] <= BRIGHT_RESET;
            hue_ff[i]    <= HUE_RESET;
            effect_ff[i] <= EFF_NONE;
            speed_ff[i]  <= SPEED_RESET;
            amount_ff[i] <= 16'd0;
         end
      end else begin
         state_ff     <= state_in;
         room_ff      <= room_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
         on_ff        <= on_in;
         bright_ff    <= bright_in;
         hue_ff       <= hue_in;
         effect_ff    <= effect_in;
         speed_ff     <= speed_in;
         amount_ff    <= amount_in;
      end
      rsp_ff   <= rsp_in;
      time_ff  <= time_in;
      prod_ff  <= prod_in;
      hi_ff    <= hi_in;
      s_neg_ff <= s_neg_in;
      b_ff     <= b_in;
      w_ff     <= w_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `RLEE_ASSERT_HOLDS(a_rsp_idle, clock, reset, !rsp_valid || !busy, "result shown while busy")
   `RLEE_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe repeated")
   `RLEE_ASSERT_HOLDS(a_bright_range, clock, reset, bright_ff[room_ff] <= BRIGHT_MAX, "brightness above full")
   `RLEE_ASSERT_HOLDS(a_hue_range, clock, reset, {1'b0, hue_ff[room_ff]} < HUE_FULL, "hue not wrapped")
   `RLEE_ASSERT_NEXT(a_long_ops_busy, clock, reset, start && !busy && (req_item.operation == OP_TICK || req_item.operation == OP_READ_COLOR), busy, "tick or read did not start")
endmodule

FILE: tb/room_light_effect_engine_core_tb.sv
module room_light_effect_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rlee_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   room_light_effect_engine_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   req_item_type pending_items[$];
   rsp_item_type expected_colors[$];
   int           error_count = 0;
   int           idle_pct = 0;
   longint       cycle_count = 0;
   bit           driver_done = 1'b0;

   bit          room_on[ROOM_COUNT];
   int unsigned room_bright[ROOM_COUNT];
   int unsigned room_hue[ROOM_COUNT];
   int unsigned room_effect[ROOM_COUNT];
   int unsigned room_speed[ROOM_COUNT];
   int unsigned room_amount[ROOM_COUNT];
   int          sine_lut[SINE_ENTRIES];

   function automatic int sine_value(int unsigned k);
      longint unsigned p, r, a, a2, term, v;
      longint          sum;
      int unsigned     quad;
      p    = (longint'(k) << 32) / SINE_ENTRIES;
      quad = 32'(p >> 30);
      r    = p & 64'h3FFF_FFFF;
      if (quad & 1) r = 64'h4000_0000 - r;
      a    = (r * 64'd1686629713) >> 30;
      a2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (int n = 1; n <= 5; n++) begin
         term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n & 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      return (quad >= 2) ? -int'(v) : int'(v);
   endfunction

   function automatic int effect_delta(int s, int unsigned amt, int unsigned gain);
      longint unsigned m;
      int              q;
      m = longint'(s < 0 ? -s : s) * amt * gain;
      q = int'((m + (64'd1 << 29)) >> 30);
      return s < 0 ? -q : q;
   endfunction

   function automatic logic [15:0] channel_level(int unsigned b, int unsigned w);
      return 16'((64'd65535 * b * w) / (64'd25600 * 64'd19200));
   endfunction

   task automatic reset_rooms();
      for (int i = 0; i < ROOM_COUNT; i++) begin
         room_on[i] = 1; room_bright[i] = 15360; room_hue[i] = 13440;
         room_effect[i] = 0; room_speed[i] = 256; room_amount[i] = 0;
      end
      for (int k = 0; k < SINE_ENTRIES; k++) sine_lut[k] = sine_value(k);
   endtask

   task automatic apply_item(req_item_type it);
      int unsigned     rm, b, h, sec, f, wmid, wr, wg, wb;
      longint unsigned prod, ph, hi, lo;
      int              s, nb, nh;
      rsp_item_type    c;
      rm = 32'(it.room);
      case (op_type'(it.operation))
         OP_SET_ROOM: begin
            room_on[rm]     = it.light_on;
            room_bright[rm] = it.level > 25600 ? 25600 : 32'(it.level);
            room_hue[rm]    = 32'(it.hue_in) % 23040;
         end
         OP_SET_EFFECT: begin
            room_effect[rm] = 32'(it.effect_kind);
            room_speed[rm]  = 32'(it.rate);
            room_amount[rm] = 32'(it.depth);
         end
         OP_TICK: begin
            for (int i = 0; i < ROOM_COUNT; i++) begin
               if (room_effect[i] != EFF_PULSE && room_effect[i] != EFF_WAVE) continue;
               prod = longint'(it.time_now) * room_speed[i];
               if (room_effect[i] == EFF_PULSE) ph = prod & 64'hFF_FFFF;
               else begin
                  hi = (((prod >> 24) * 64'd683565276) & 64'hFFFF_FFFF) << 24;
                  lo = (prod & 64'hFF_FFFF) * 64'd683565276;
                  ph = ((hi + lo) >> 32) & 64'hFF_FFFF;
               end
               ph = (ph + longint'(i) * 1602106) & 64'hFF_FFFF;
               s  = sine_lut[(ph * SINE_ENTRIES) >> 24];
               nb = int'(room_bright[i]) + effect_delta(s, room_amount[i], 5120);
               if (nb < 0) nb = 0;
               if (nb > 25600) nb = 25600;
               room_bright[i] = nb;
               if (room_effect[i] == EFF_WAVE) begin
                  nh = int'(room_hue[i]) + 23040 + effect_delta(s, room_amount[i], 1280);
                  room_hue[i] = nh % 23040;
               end
            end
         end
         default: begin
            b    = room_on[rm] ? room_bright[rm] : 0;
            h    = room_hue[rm] % 23040;
            sec  = h / 3840;
            f    = h % 3840;
            wmid = 3840 + 4 * ((sec & 1) ? (3840 - f) : f);
            case (sec)
               0: begin wr = 19200; wg = wmid; wb = 3840; end
               1: begin wr = wmid; wg = 19200; wb = 3840; end
               2: begin wr = 3840; wg = 19200; wb = wmid; end
               3: begin wr = 3840; wg = wmid; wb = 19200; end
               4: begin wr = wmid; wg = 3840; wb = 19200; end
               default: begin wr = 19200; wg = 3840; wb = wmid; end
            endcase
            c.red = channel_level(b, wr);
            c.green = channel_level(b, wg);
            c.blue = channel_level(b, wb);
            expected_colors.push_back(c);
         end
      endcase
   endtask

   function automatic req_item_type random_item(int unsigned op);
      req_item_type it;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(req_item_type)-1:0];
      it.operation = 2'(op);
      if ($urandom_range(0, 3) == 0) it.level = 15'($urandom_range(25500, 25700));
      if ($urandom_range(0, 3) == 0) it.depth = 16'($urandom_range(32760, 32768));
      if ($urandom_range(0, 2) == 0) it.rate = 16'($urandom_range(0, 1024));
      return it;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !busy) && start) begin
         start <= 1'b1;
      end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
         req_item <= pending_items[0];
         apply_item(pending_items.pop_front());
         start <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_colors.size() == 0) begin
            $error("unexpected result %h", rsp_item);
            error_count++;
         end else begin
            rsp_item_type e;
            e = expected_colors.pop_front();
            if (rsp_item.red !== e.red) begin
               $error("red exp %0d got %0d", e.red, rsp_item.red); error_count++;
            end
            if (rsp_item.green !== e.green) begin
               $error("green exp %0d got %0d", e.green, rsp_item.green); error_count++;
            end
            if (rsp_item.blue !== e.blue) begin
               $error("blue exp %0d got %0d", e.blue, rsp_item.blue); error_count++;
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("room_light_effect_engine_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      int           pcts[4] = '{0, 67, 0, 29};
      reset_rooms();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < 4; r++) begin
         it = '0; it.operation = OP_READ_COLOR; it.room = 2'(r); pending_items.push_back(it);
      end
      for (int h = 0; h < 7; h++) begin
         it = '0; it.operation = OP_SET_ROOM; it.room = 2'(h % 4); it.light_on = h != 3;
         it.level = (h == 0) ? 15'h7FFF : 15'(25600 - h);
         it.hue_in = (h == 6) ? 16'hFFFF : 16'(h * 3840 + 100);
         pending_items.push_back(it);
         it.operation = OP_READ_COLOR; pending_items.push_back(it);
      end
      for (int r = 0; r < 4; r++) begin
         it = '0; it.operation = OP_SET_EFFECT; it.room = 2'(r); it.effect_kind = 2'(r);
         it.rate = (r == 1) ? 16'hFFFF : 16'd300; it.depth = 16'hFFFF;
         pending_items.push_back(it);
      end
      it = '0; it.operation = OP_TICK; it.time_now = 32'hFFFF_FFFF; pending_items.push_back(it);
      it.operation = OP_READ_COLOR; it.room = 2'd2; pending_items.push_back(it);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = pcts[ph];
         for (int n = 0; n < 112; n++) begin
            int unsigned w;
            w = $urandom_range(0, 9);
            pending_items.push_back(random_item(w < 2 ? OP_SET_ROOM : w < 4 ? OP_SET_EFFECT
                                                : w < 6 ? OP_TICK : OP_READ_COLOR));
         end
         while (pending_items.size() > 0 || start) @(posedge clock);
         while (busy || expected_colors.size() > 0) @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_colors.size() == 0)
         $display("room_light_effect_engine_core_tb: done, clean");
      else
         $display("room_light_effect_engine_core_tb: done, errors");
      $finish;
   end
endmodule
